// ===== hdl/pipw_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon winding package
// Word types, widths and helpers for the winding-number test.
// ----------------------------------------------------------------------------
package pipw_pkg;

    localparam int COORD_BITS   = 16;
    localparam int MAX_VERTICES = 1024;
    localparam int MIN_VERTICES = 3;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int WIND_W = 11;
    localparam int WOUT_W = 12;

    localparam logic signed [WIND_W-1:0] WIND_MAX = {1'b0, {(WIND_W-1){1'b1}}};
    localparam logic signed [WIND_W-1:0] WIND_MIN = {1'b1, {(WIND_W-1){1'b0}}};

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef struct packed {
        logic                         kind;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last;
    } t_in_word;

    typedef struct packed {
        logic                     inside_res;
        logic signed [WOUT_W-1:0] winding_number;
        logic                     too_few_vertices;
    } t_out_word;

    // Quadrant codes follow the table {0,1 / 3,2} indexed by (dy<0, dx<0).
    function automatic logic [1:0] quadrant(input logic dy_neg, input logic dx_neg);
        logic [1:0] q;
        case ({dy_neg, dx_neg})
            2'b00:   q = 2'd0;
            2'b01:   q = 2'd1;
            2'b10:   q = 2'd3;
            default: q = 2'd2;
        endcase
        return q;
    endfunction

    // Winding change for one edge. The flag ge tells that the cross product
    // of the previous and current vertices is not negative.
    function automatic logic signed [1:0] edge_delta(input logic [1:0] pq,
                                                     input logic [1:0] cq,
                                                     input logic ge);
        logic signed [2:0] diff;
        logic signed [1:0] d;
        diff = $signed({1'b0, cq}) - $signed({1'b0, pq});
        case (diff)
            -3'sd3:  d = 2'sd1;
            3'sd3:   d = -2'sd1;
            -3'sd2:  d = ge ? 2'sd1 : 2'sd0;
            3'sd2:   d = ge ? 2'sd0 : -2'sd1;
            default: d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [WIND_W-1:0] sat_add(input logic signed [WIND_W-1:0] s,
                                                         input logic signed [1:0] d);
        logic signed [WIND_W:0] w;
        logic signed [WIND_W-1:0] r;
        w = {s[WIND_W-1], s} + {{(WIND_W-1){d[1]}}, d};
        if (w > $signed({WIND_MAX[WIND_W-1], WIND_MAX})) begin
            r = WIND_MAX;
        end else if (w < $signed({WIND_MIN[WIND_W-1], WIND_MIN})) begin
            r = WIND_MIN;
        end else begin
            r = w[WIND_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/point_in_polygon_winding_core.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon winding core
// Streams polygon vertices around a test point and reports the winding count.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Word
//  in       | input     | i_in_valid/o_in_stall   | kind, point_x, point_y, last
//  out      | output    | o_out_valid/i_out_stall | inside_res, winding_number,
//           |           |                         | too_few_vertices
//
//  One word is taken per cycle while o_in_stall is low; each result is registered.
//  The input register forms the offset and quadrant; the second stage does the
//  two cross products per vertex and the saturating winding update.
//  Reset is synchronous and clears the test point, the sums and both valid flags.
//  A stalled output register blocks only words that produce a result.
// ----------------------------------------------------------------------------
module point_in_polygon_winding_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pipw_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pipw_pkg::t_out_word o_out_word
);
    import pipw_pkg::*;

    logic                         in_acc;
    logic                         s2_go;
    logic                         s2_emit;
    logic                         out_free;

    logic signed [COORD_BITS-1:0] r_test_x;
    logic signed [COORD_BITS-1:0] r_test_y;

    logic                         r_s1_vld;
    logic                         r_s1_kind;
    logic                         r_s1_last;
    logic signed [DIFF_W-1:0]     r_s1_dx;
    logic signed [DIFF_W-1:0]     r_s1_dy;
    logic [1:0]                   r_s1_quad;
    logic signed [DIFF_W-1:0]     n_s1_dx;
    logic signed [DIFF_W-1:0]     n_s1_dy;

    logic signed [DIFF_W-1:0]     r_first_dx;
    logic signed [DIFF_W-1:0]     r_first_dy;
    logic [1:0]                   r_first_quad;
    logic signed [DIFF_W-1:0]     r_prev_dx;
    logic signed [DIFF_W-1:0]     r_prev_dy;
    logic [1:0]                   r_prev_quad;
    logic signed [WIND_W-1:0]     r_sum;
    logic [CNT_W-1:0]             r_count;

    logic signed [DIFF_W-1:0]     f_dx;
    logic signed [DIFF_W-1:0]     f_dy;
    logic [1:0]                   f_quad;
    logic signed [PROD_W-1:0]     p_open_l;
    logic signed [PROD_W-1:0]     p_open_r;
    logic signed [PROD_W-1:0]     p_close_l;
    logic signed [PROD_W-1:0]     p_close_r;
    logic signed [1:0]            d_open;
    logic signed [1:0]            d_close;
    logic signed [WIND_W-1:0]     n_sum_open;
    logic signed [WIND_W-1:0]     n_sum_close;
    logic [CNT_W-1:0]             n_count;
    logic                         n_few;
    logic                         cnt_zero;

    logic                         r_out_vld;
    t_out_word                    r_out_word;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s2_emit    = r_s1_vld && (r_s1_kind == KIND_VERTEX) && r_s1_last;
    assign s2_go      = r_s1_vld && (out_free || !s2_emit);
    assign o_in_stall = r_s1_vld && !s2_go;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign n_s1_dx = {i_in_word.point_x[COORD_BITS-1], i_in_word.point_x}
                   - {r_test_x[COORD_BITS-1], r_test_x};
    assign n_s1_dy = {i_in_word.point_y[COORD_BITS-1], i_in_word.point_y}
                   - {r_test_y[COORD_BITS-1], r_test_y};

    // The test point is taken when its word enters, so the next vertex sees it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_test_x <= '0;
            r_test_y <= '0;
        end else begin
            if (in_acc || s2_go) begin
                r_s1_vld <= in_acc;
            end
            if (in_acc && (i_in_word.kind == KIND_START)) begin
                r_test_x <= i_in_word.point_x;
                r_test_y <= i_in_word.point_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind <= i_in_word.kind;
            r_s1_last <= i_in_word.last;
            r_s1_dx   <= n_s1_dx;
            r_s1_dy   <= n_s1_dy;
            r_s1_quad <= quadrant(n_s1_dy[DIFF_W-1], n_s1_dx[DIFF_W-1]);
        end
    end

    assign cnt_zero = (r_count == '0);
    assign f_dx     = cnt_zero ? r_s1_dx : r_first_dx;
    assign f_dy     = cnt_zero ? r_s1_dy : r_first_dy;
    assign f_quad   = cnt_zero ? r_s1_quad : r_first_quad;

    assign p_open_l  = r_prev_dx * r_s1_dy;
    assign p_open_r  = r_prev_dy * r_s1_dx;
    assign p_close_l = r_s1_dx * f_dy;
    assign p_close_r = r_s1_dy * f_dx;

    assign d_open  = cnt_zero ? 2'sd0
                   : edge_delta(r_prev_quad, r_s1_quad, p_open_l >= p_open_r);
    assign d_close = edge_delta(r_s1_quad, f_quad, p_close_l >= p_close_r);

    assign n_sum_open  = sat_add(r_sum, d_open);
    assign n_sum_close = sat_add(n_sum_open, d_close);
    assign n_count     = (r_count < CNT_W'(MAX_VERTICES)) ? r_count + 1'b1 : r_count;
    assign n_few       = (n_count < CNT_W'(MIN_VERTICES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (s2_go) begin
            if ((r_s1_kind == KIND_START) || r_s1_last) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum_open;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && (r_s1_kind == KIND_VERTEX)) begin
            r_prev_dx   <= r_s1_dx;
            r_prev_dy   <= r_s1_dy;
            r_prev_quad <= r_s1_quad;
            if (cnt_zero) begin
                r_first_dx   <= r_s1_dx;
                r_first_dy   <= r_s1_dy;
                r_first_quad <= r_s1_quad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= s2_go && s2_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s2_go && s2_emit) begin
            r_out_word.inside_res       <= !n_few && (n_sum_close != '0);
            r_out_word.winding_number   <= WOUT_W'(n_sum_close);
            r_out_word.too_few_vertices <= n_few;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go && (r_s1_kind == KIND_START) |=> (r_count == '0) && (r_sum == '0))
        else $error("start word did not clear the running sums");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(s2_go && s2_emit))
        else $error("result appeared without a last vertex");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count passed its limit");

    a_few_not_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.too_few_vertices |-> !o_out_word.inside_res)
        else $error("degenerate polygon reported as inside");

endmodule
